// ----- sv/crtx_pkg.sv -----
package crtx_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TIME_W = 48;
  localparam int STEP_W = $clog2(TIME_W);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_UPDATE = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_PERIOD = 3'd1,
    ST_FULL       = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_INVALID    = 3'd4
  } status_e;

  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [28:0]        frame_id;
    logic               extended;
    logic [3:0]         data_len;
    logic [63:0]        payload;
    logic [15:0]        period_ms;
    logic signed [15:0] offset_ms;
    logic [15:0]        advance_ms;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [28:0] out_id;
    logic        out_extended;
    logic [3:0]  out_len;
    logic [63:0] out_payload;
    logic [2:0]  status;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [28:0]       id;
    logic              ext;
    logic [3:0]        len;
    logic [63:0]       payload;
    logic [15:0]       period;
    logic [TIME_W-1:0] due;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_SCAN,
    S_DIV
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic apply;
    logic emit_item;
    logic div_start;
    logic commit;
    logic emit_end;
  } ctrl_t;

  typedef struct packed {
    logic at_end;
    logic match;
    logic due_now;
    logic div_done;
  } stat_t;

  function automatic logic [63:0] trim_payload(input logic [63:0] pay, input logic [3:0] len);
    logic [63:0] res;
    res = '0;
    for (int b = 0; b < 8; b++) begin
      if (len > 4'(b)) res[b*8 +: 8] = pay[b*8 +: 8];
    end
    return res;
  endfunction

endpackage

// ----- sv/can_periodic_tx_scheduler_top.sv -----
// Periodic CAN transmit table. A word is taken when start is high and busy is low; busy
// then stays high until the command is done. Results leave one per out_valid pulse and the
// receiver cannot hold them off. Add, update and remove search the table one slot a cycle.
// A tick scans every entry; for each due entry the 48-step serial remainder unit moves its
// due time forward, and the tick gives one word per due entry and a closing status word.
module can_periodic_tx_scheduler_top
  import crtx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  ctrl_t ctrl;
  stat_t stat;

  crtx_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_word.cmd),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  crtx_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ----- sv/crtx_div.sv -----
module crtx_div
  import crtx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [15:0]       divisor,
  output logic              done,
  output logic [15:0]       rem
);

  logic [TIME_W-1:0] dq_r, dq_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [15:0]       dvs_r, dvs_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [16:0]       shifted;

  // restoring division, one quotient bit a cycle; only the remainder is kept
  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, dq_r[TIME_W-1]};
    if (start) begin
      dq_nxt  = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      dq_nxt  = {dq_r[TIME_W-2:0], 1'b0};
      rem_nxt = (shifted >= {1'b0, dvs_r}) ? 16'(shifted - {1'b0, dvs_r}) : shifted[15:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(TIME_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- sv/crtx_ctrl.sv -----
module crtx_ctrl
  import crtx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_cmd,
  input  stat_t      stat,
  output ctrl_t      ctrl,
  output logic       busy
);

  state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          if (in_cmd == CMD_TICK) begin
            state_nxt = S_SCAN;
          end else if (in_cmd == CMD_ADD || in_cmd == CMD_UPDATE || in_cmd == CMD_REMOVE) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_SEARCH: begin
        if (stat.at_end || stat.match) begin
          state_nxt = S_APPLY;
        end else begin
          ctrl.step = 1'b1;
        end
      end
      S_APPLY: begin
        ctrl.apply = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        priority if (stat.at_end) begin
          ctrl.emit_end = 1'b1;
          state_nxt     = S_IDLE;
        end else if (stat.due_now) begin
          ctrl.emit_item = 1'b1;
          ctrl.div_start = 1'b1;
          state_nxt      = S_DIV;
        end else begin
          ctrl.step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          ctrl.commit = 1'b1;
          ctrl.step   = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- sv/crtx_dp.sv -----
module crtx_dp
  import crtx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  ctrl_t     ctrl,
  output stat_t     stat,
  output logic      out_valid,
  output out_word_t out_word
);

  entry_t            tbl_r [DEPTH];
  entry_t            tbl_nxt [DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [TIME_W-1:0] clock_r, clock_nxt;
  in_word_t          word_r, word_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  entry_t            cur;
  logic              found;
  logic              bad;
  logic [TIME_W-1:0] off;
  logic              div_done;
  logic [15:0]       div_rem;
  logic [15:0]       div_den;

  assign cur   = tbl_r[idx_r[IDX_W-1:0]];
  assign found = (idx_r < count_r);
  assign bad   = (!cur.ext && cur.id > 29'h7FF) || cur.len > 4'd8;
  assign off   = word_r.offset_ms[15] ? '0 : TIME_W'(unsigned'(word_r.offset_ms));
  assign div_den = (cur.period == 16'd0) ? 16'd1 : cur.period;

  assign stat.at_end   = !found;
  assign stat.match    = (cur.id == word_r.frame_id) && (cur.ext == word_r.extended);
  assign stat.due_now  = (clock_r >= cur.due);
  assign stat.div_done = div_done;

  crtx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (clock_r - cur.due),
    .divisor  (div_den),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    tbl_nxt       = tbl_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    clock_nxt     = clock_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    if (ctrl.load) begin
      word_nxt = in_word;
      idx_nxt  = '0;
      if (in_word.cmd == CMD_TICK) clock_nxt = clock_r + TIME_W'(in_word.advance_ms);
    end

    if (ctrl.step) idx_nxt = idx_r + 1'b1;

    if (ctrl.apply) begin
      out_valid_nxt             = 1'b1;
      out_word_nxt              = '0;
      out_word_nxt.kind         = KIND_STATUS;
      out_word_nxt.out_id       = word_r.frame_id;
      out_word_nxt.out_extended = word_r.extended;
      out_word_nxt.last         = 1'b1;
      out_word_nxt.status       = ST_OK;
      unique case (word_r.cmd)
        CMD_ADD: begin
          priority if (word_r.period_ms == 16'd0) begin
            out_word_nxt.status = ST_BAD_PERIOD;
          end else if (!found && count_r >= CNT_W'(DEPTH)) begin
            out_word_nxt.status = ST_FULL;
          end else begin
            // when the key is absent, idx_r already sits at count_r
            if (!found) count_nxt = count_r + 1'b1;
            tbl_nxt[idx_r[IDX_W-1:0]].id      = word_r.frame_id;
            tbl_nxt[idx_r[IDX_W-1:0]].ext     = word_r.extended;
            tbl_nxt[idx_r[IDX_W-1:0]].len     = word_r.data_len;
            tbl_nxt[idx_r[IDX_W-1:0]].payload = trim_payload(word_r.payload, word_r.data_len);
            tbl_nxt[idx_r[IDX_W-1:0]].period  = word_r.period_ms;
            tbl_nxt[idx_r[IDX_W-1:0]].due     = clock_r + off;
          end
        end
        CMD_UPDATE: begin
          if (!found) begin
            out_word_nxt.status = ST_NOT_FOUND;
          end else begin
            tbl_nxt[idx_r[IDX_W-1:0]].len     = word_r.data_len;
            tbl_nxt[idx_r[IDX_W-1:0]].payload = trim_payload(word_r.payload, word_r.data_len);
          end
        end
        CMD_REMOVE: begin
          if (!found) begin
            out_word_nxt.status = ST_NOT_FOUND;
          end else begin
            // close up: every slot at or past the hit, but the last, takes its upper neighbor
            for (int j = 0; j < DEPTH - 1; j++) begin
              if (CNT_W'(j) >= idx_r) tbl_nxt[j] = tbl_r[j+1];
            end
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end

    if (ctrl.emit_item) begin
      out_valid_nxt             = 1'b1;
      out_word_nxt              = '0;
      out_word_nxt.out_id       = cur.id;
      out_word_nxt.out_extended = cur.ext;
      if (bad) begin
        out_word_nxt.kind   = KIND_STATUS;
        out_word_nxt.status = ST_INVALID;
      end else begin
        out_word_nxt.kind        = KIND_FRAME;
        out_word_nxt.out_len     = cur.len;
        out_word_nxt.out_payload = cur.payload;
        out_word_nxt.status      = ST_OK;
      end
    end

    if (ctrl.emit_end) begin
      out_valid_nxt       = 1'b1;
      out_word_nxt        = '0;
      out_word_nxt.kind   = KIND_STATUS;
      out_word_nxt.status = ST_OK;
      out_word_nxt.last   = 1'b1;
    end

    // next due = now - ((now - due) mod period) + period
    if (ctrl.commit) begin
      tbl_nxt[idx_r[IDX_W-1:0]].due = clock_r - TIME_W'(div_rem) + TIME_W'(div_den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clock_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      clock_r     <= clock_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tbl_r      <= tbl_nxt;
    word_r     <= word_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- dv/can_periodic_tx_scheduler_top_test.sv -----
`timescale 1ns / 100ps

module can_periodic_tx_scheduler_top_test;
  import crtx_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  can_periodic_tx_scheduler_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // shadow copy of the transmit table
  entry_t            sched_tab[DEPTH];
  int unsigned       sched_count;
  logic [TIME_W-1:0] sched_now;

  in_word_t  cmd_queue[$];
  out_word_t expected_words[$];
  int        fail_count;
  int        idle_cycles;
  bit        sender_hold;
  bit        sender_quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_word_t mk_word(logic kind, logic [28:0] id, logic ext,
                                        logic [3:0] len, logic [63:0] pay,
                                        status_e st, logic last);
    out_word_t w;
    w.kind = kind;
    w.out_id = id;
    w.out_extended = ext;
    w.out_len = len;
    w.out_payload = pay;
    w.status = st;
    w.last = last;
    return w;
  endfunction

  function automatic logic [63:0] keep_bytes(logic [63:0] pay, logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++)
      if (len > b) m[b*8 +: 8] = 8'hFF;
    return pay & m;
  endfunction

  function automatic int find_slot(logic [28:0] id, logic ext);
    for (int i = 0; i < sched_count; i++)
      if (sched_tab[i].id == id && sched_tab[i].ext == ext) return i;
    return -1;
  endfunction

  task automatic predict_schedule(input in_word_t w);
    int                idx;
    status_e           st;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] steps;
    logic [15:0]       off;
    bit                bad;
    st = ST_OK;
    case (w.cmd)
      CMD_ADD: begin
        off = w.offset_ms[15] ? 16'd0 : w.offset_ms;
        idx = find_slot(w.frame_id, w.extended);
        if (w.period_ms == 0) st = ST_BAD_PERIOD;
        else if (idx < 0 && sched_count >= DEPTH) st = ST_FULL;
        else begin
          if (idx < 0) begin
            idx = sched_count;
            sched_count++;
            sched_tab[idx].id = w.frame_id;
            sched_tab[idx].ext = w.extended;
          end
          sched_tab[idx].len = w.data_len;
          sched_tab[idx].payload = keep_bytes(w.payload, w.data_len);
          sched_tab[idx].period = w.period_ms;
          sched_tab[idx].due = sched_now + off;
        end
      end
      CMD_UPDATE: begin
        idx = find_slot(w.frame_id, w.extended);
        if (idx < 0) st = ST_NOT_FOUND;
        else begin
          sched_tab[idx].len = w.data_len;
          sched_tab[idx].payload = keep_bytes(w.payload, w.data_len);
        end
      end
      CMD_REMOVE: begin
        idx = find_slot(w.frame_id, w.extended);
        if (idx < 0) st = ST_NOT_FOUND;
        else begin
          for (int i = idx; i + 1 < sched_count; i++) sched_tab[i] = sched_tab[i+1];
          sched_count--;
        end
      end
      CMD_CLEAR: sched_count = 0;
      CMD_TICK: begin
        sched_now = sched_now + w.advance_ms;
        for (int i = 0; i < sched_count; i++) begin
          due = sched_tab[i].due;
          if (sched_now < due) continue;
          bad = (!sched_tab[i].ext && sched_tab[i].id > 29'h7FF) || sched_tab[i].len > 8;
          if (bad)
            expected_words.push_back(mk_word(KIND_STATUS, sched_tab[i].id, sched_tab[i].ext,
                                             4'd0, 64'd0, ST_INVALID, 1'b0));
          else
            expected_words.push_back(mk_word(KIND_FRAME, sched_tab[i].id, sched_tab[i].ext,
                                             sched_tab[i].len, sched_tab[i].payload, ST_OK,
                                             1'b0));
          steps = (sched_now - due) / sched_tab[i].period + 1;
          sched_tab[i].due = due + steps * sched_tab[i].period;
        end
        expected_words.push_back(mk_word(KIND_STATUS, 29'd0, 1'b0, 4'd0, 64'd0, ST_OK, 1'b1));
        return;
      end
      default: ;
    endcase
    expected_words.push_back(mk_word(KIND_STATUS, w.frame_id, w.extended, 4'd0, 64'd0, st,
                                     1'b1));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_word <= '0;
    end else if (start && busy) begin
      // hold current word
    end else begin
      if (start && !busy) predict_schedule(in_word);
      if (cmd_queue.size() > 0 && !sender_hold && (sender_quiet || $urandom_range(99) >= 24))
      begin
        start <= 1'b1;
        in_word <= cmd_queue.pop_front();
      end else begin
        start <= 1'b0;
        in_word <= '0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_word.kind !== want.kind || out_word.out_id !== want.out_id ||
            out_word.out_extended !== want.out_extended || out_word.out_len !== want.out_len ||
            out_word.out_payload !== want.out_payload || out_word.status !== want.status ||
            out_word.last !== want.last) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_word);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // random key, mostly from a small pool so hits are common
  function automatic in_word_t rand_word(cmd_e c);
    in_word_t w;
    w.cmd = c;
    w.extended = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: w.frame_id = 29'($urandom_range(7));
      1: w.frame_id = 29'(29'h7F8 + $urandom_range(15));
      2: w.frame_id = 29'(29'h1FFFFFF8 + $urandom_range(7));
      default: w.frame_id = 29'($urandom);
    endcase
    w.data_len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    w.payload = {$urandom, $urandom};
    w.period_ms = ($urandom_range(19) == 0) ? 16'd0 :
                  ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
    w.offset_ms = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(30));
    w.advance_ms = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(25));
    return w;
  endfunction

  task automatic queue_cmd(cmd_e c, logic [28:0] id, logic ext, logic [3:0] len,
                           logic [63:0] pay, logic [15:0] per, logic [15:0] off,
                           logic [15:0] adv);
    in_word_t w;
    w = '{c, id, ext, len, pay, per, off, adv};
    cmd_queue.push_back(w);
  endtask

  task automatic drain;
    while (cmd_queue.size() > 0 || start) @(posedge clk);
    while (busy || expected_words.size() > 0) @(posedge clk);
  endtask

  initial begin
    int r;
    rst_n = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    sender_hold = 1'b0;
    sender_quiet = 1'b0;
    sched_count = 0;
    sched_now = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    queue_cmd(CMD_ADD, 29'h7FF, 1'b0, 4'd8, '1, 16'd1, 16'd0, 16'd0);
    queue_cmd(CMD_ADD, 29'h800, 1'b0, 4'd2, '1, 16'd3, 16'hFFFF, 16'd0);
    queue_cmd(CMD_ADD, 29'h1FFFFFFF, 1'b1, 4'd15, '1, 16'hFFFF, 16'h7FFF, 16'd0);
    queue_cmd(CMD_ADD, 29'd5, 1'b1, 4'd0, '1, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_ADD, 29'd5, 1'b0, 4'd3, 64'h0123456789ABCDEF, 16'd2, 16'h8000, 16'd0);
    queue_cmd(CMD_TICK, '0, 1'b0, '0, '0, '0, '0, 16'd0);
    queue_cmd(CMD_TICK, '0, 1'b0, '0, '0, '0, '0, 16'd7);
    queue_cmd(CMD_UPDATE, 29'd5, 1'b0, 4'd9, '1, '0, '0, '0);
    queue_cmd(CMD_UPDATE, 29'd5, 1'b1, 4'd1, '1, '0, '0, '0);
    queue_cmd(CMD_ADD, 29'h7FF, 1'b0, 4'd1, 64'hAA, 16'd5, 16'd2, 16'd0);
    queue_cmd(CMD_TICK, '0, 1'b0, '0, '0, '0, '0, 16'hFFFF);
    queue_cmd(CMD_REMOVE, 29'h800, 1'b0, '0, '0, '0, '0, '0);
    queue_cmd(CMD_REMOVE, 29'h800, 1'b0, '0, '0, '0, '0, '0);
    queue_cmd(cmd_e'(3'd5), 29'd1, 1'b1, '0, '0, '0, '0, '0);
    queue_cmd(cmd_e'(3'd7), 29'd2, 1'b0, '0, '0, '0, '0, '0);
    queue_cmd(CMD_TICK, '0, 1'b0, '0, '0, '0, '0, 16'd3);
    queue_cmd(CMD_CLEAR, 29'd9, 1'b0, '0, '0, '0, '0, '0);
    for (int i = 0; i < DEPTH + 1; i++)
      queue_cmd(CMD_ADD, 29'(i), 1'b1, 4'd8, {$urandom, $urandom}, 16'd4, 16'(i % 3), '0);
    queue_cmd(CMD_TICK, '0, 1'b0, '0, '0, '0, '0, 16'd2);
    drain();
    sender_hold = 1'b1;
    repeat (5) @(posedge clk);
    sender_hold = 1'b0;
    queue_cmd(CMD_CLEAR, '0, 1'b0, '0, '0, '0, '0, '0);

    // random, with a quiet stretch in the middle
    for (int n = 0; n < 330; n++) begin
      r = $urandom_range(99);
      if (n == 120) begin
        drain();
        sender_quiet = 1'b1;
      end
      if (n == 200) begin
        drain();
        sender_quiet = 1'b0;
      end
      if (r < 40) cmd_queue.push_back(rand_word(CMD_ADD));
      else if (r < 50) cmd_queue.push_back(rand_word(CMD_UPDATE));
      else if (r < 62) cmd_queue.push_back(rand_word(CMD_REMOVE));
      else if (r < 65) cmd_queue.push_back(rand_word(CMD_CLEAR));
      else if (r < 67) cmd_queue.push_back(rand_word(cmd_e'(3'($urandom_range(5, 7)))));
      else cmd_queue.push_back(rand_word(CMD_TICK));
    end
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/crtx_pkg.sv
sv/crtx_div.sv
sv/crtx_ctrl.sv
sv/crtx_dp.sv
sv/can_periodic_tx_scheduler_top.sv
dv/can_periodic_tx_scheduler_top_test.sv
